FILE: hdl/fdsle_pkg.sv
// shared types, constants and widths for the frame delta skip/literal encoder
`default_nettype none
package fdsle_pkg;

  localparam int MAX_FRAME_BYTES = 8192;
  localparam int MAX_LITERAL     = 127;
  localparam int MAX_SKIP        = 128;
  localparam int MAX_RESULTS     = 4;
  localparam int QUEUE_DEPTH     = 2;

  localparam int POS_W      = $clog2(MAX_FRAME_BYTES);
  localparam int FLEN_W     = 14;
  localparam int LIT_W      = $clog2(MAX_LITERAL + 1);
  localparam int SKIP_W     = $clog2(MAX_SKIP + 1);
  localparam int WPOS_W     = 15;
  localparam int OFS_W      = 14;
  localparam int RES_CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int RES_IDX_W  = $clog2(MAX_RESULTS);
  localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FLEN_W-1:0] FRAME_LENGTH_RESET = 14'd8000;
  localparam logic [7:0]        SKIP_CODE          = 8'h80;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       key_frame;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic [OFS_W-1:0]  out_offset;
    logic              out_trailer;
    logic              key_used;
    logic [WPOS_W-1:0] body_length;
  } out_t;

  // classified word passed from front to back
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       changed;
    logic       last;
    logic       key;
  } cls_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

endpackage
`default_nettype wire

FILE: hdl/fdsle_front.sv
// front end: accepts frame bytes, keeps the previous frame and classifies each byte
`default_nettype none
module fdsle_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire fdsle_pkg::in_t                in_data,
  input  wire logic                          cfg_we,
  input  wire logic [fdsle_pkg::FLEN_W-1:0]  cfg_data,
  output fdsle_pkg::link_t                   q_link_out,
  input  wire logic                          q_ready,
  output fdsle_pkg::cls_t                    q_data
);

  localparam int POS_W = fdsle_pkg::POS_W;
  localparam int CMP_W = (POS_W + 1 > fdsle_pkg::FLEN_W) ? POS_W + 1 : fdsle_pkg::FLEN_W;

  logic [7:0] mem [fdsle_pkg::MAX_FRAME_BYTES];

  logic [fdsle_pkg::FLEN_W-1:0] frame_length;
  logic [POS_W-1:0]             byte_position;
  logic                         key_pending;
  logic                         key_in_frame;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_key;
  logic       s1_last;
  logic [7:0] rd_byte;

  logic             accept;
  logic             last;
  logic             key_now;
  logic [CMP_W-1:0] len_eff;
  logic [CMP_W-1:0] pos_inc;

  assign in_stall = s1_valid && !q_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (frame_length == '0) begin
      len_eff = CMP_W'(1);
    end else if (CMP_W'(frame_length) > CMP_W'(fdsle_pkg::MAX_FRAME_BYTES)) begin
      len_eff = CMP_W'(fdsle_pkg::MAX_FRAME_BYTES);
    end else begin
      len_eff = CMP_W'(frame_length);
    end
    pos_inc = CMP_W'(byte_position) + CMP_W'(1);
    last    = in_data.frame_end || (pos_inc >= len_eff);
    key_now = (byte_position == '0) ? (key_pending || in_data.key_frame) : key_in_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length  <= fdsle_pkg::FRAME_LENGTH_RESET;
      byte_position <= '0;
      key_pending   <= 1'b1;
      key_in_frame  <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      if (accept) begin
        key_in_frame  <= key_now;
        byte_position <= last ? '0 : POS_W'(pos_inc);
        if (byte_position == '0) begin
          key_pending <= 1'b0;
        end
      end
      if (cfg_we) begin
        frame_length <= cfg_data;
        key_pending  <= 1'b1;
      end
      s1_valid <= accept || in_stall;
    end
  end

  // read-before-write: the word read is last frame's byte at this position
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_byte            <= mem[byte_position];
      mem[byte_position] <= in_data.pixel_byte;
      s1_byte            <= in_data.pixel_byte;
      s1_key             <= key_now;
      s1_last            <= last;
    end
  end

  always_comb begin
    q_link_out.valid   = s1_valid;
    q_link_out.ready   = q_ready;
    q_data.pixel_byte  = s1_byte;
    q_data.changed     = s1_byte != (s1_key ? 8'd0 : rd_byte);
    q_data.last        = s1_last;
    q_data.key         = s1_key;
  end

`ifndef SYNTHESIS
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.frame_end |=> byte_position == '0)
    else $error("byte position did not restart after frame end");
`endif

endmodule
`default_nettype wire

FILE: hdl/fdsle_queue.sv
// short queue of classified words between front and back
`default_nettype none
module fdsle_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fdsle_pkg::link_t  push_link,
  input  wire fdsle_pkg::cls_t   push_data,
  output logic                   push_ready,
  output logic                   pop_valid,
  input  wire logic              pop,
  output fdsle_pkg::cls_t        pop_data
);

  localparam int QPTR_W = fdsle_pkg::QPTR_W;
  localparam int QCNT_W = fdsle_pkg::QCNT_W;

  fdsle_pkg::cls_t    slots [fdsle_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  q_count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = q_count != QCNT_W'(fdsle_pkg::QUEUE_DEPTH);
  assign pop_valid  = q_count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_link.valid && push_link.ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(fdsle_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(fdsle_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   q_count <= q_count + 1'b1;
        2'b01:   q_count <= q_count - 1'b1;
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    q_count == QCNT_W'(fdsle_pkg::QUEUE_DEPTH) && !do_pop |=> q_count == $past(q_count))
    else $error("queue count moved while full and not popped");
`endif

endmodule
`default_nettype wire

FILE: hdl/fdsle_back.sv
// back end: skip and literal run coding, result buffer and output register
`default_nettype none
module fdsle_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire fdsle_pkg::cls_t  q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output fdsle_pkg::out_t       out_data
);

  localparam int LIT_W   = fdsle_pkg::LIT_W;
  localparam int SKIP_W  = fdsle_pkg::SKIP_W;
  localparam int WPOS_W  = fdsle_pkg::WPOS_W;
  localparam int OFS_W   = fdsle_pkg::OFS_W;
  localparam int CNT_W   = fdsle_pkg::RES_CNT_W;
  localparam int IDX_W   = fdsle_pkg::RES_IDX_W;
  localparam int NRES    = fdsle_pkg::MAX_RESULTS;

  logic [SKIP_W-1:0] skip_run;
  logic              literal_active;
  logic [LIT_W-1:0]  literal_count;
  logic [OFS_W-1:0]  count_slot;
  logic [WPOS_W-1:0] write_position;
  logic              held_valid;
  logic [7:0]        held_byte;

  logic [SKIP_W-1:0] skip_run_next;
  logic              literal_active_next;
  logic [LIT_W-1:0]  literal_count_next;
  logic [OFS_W-1:0]  count_slot_next;
  logic [WPOS_W-1:0] write_position_next;
  logic              held_valid_next;
  logic [7:0]        held_byte_next;

  fdsle_pkg::out_t   res [NRES];
  logic [CNT_W-1:0]  res_count;

  fdsle_pkg::out_t   pend [NRES];
  logic [CNT_W-1:0]  pend_count;
  logic              drain;
  logic              take;

  function automatic fdsle_pkg::out_t body_word(logic [7:0] b, logic [WPOS_W-1:0] ofs);
    fdsle_pkg::out_t r;
    r.out_byte    = b;
    r.out_offset  = ofs[OFS_W-1:0];
    r.out_trailer = 1'b0;
    r.key_used    = 1'b0;
    r.body_length = '0;
    return r;
  endfunction

  function automatic logic [7:0] skip_byte(logic [SKIP_W-1:0] run);
    logic [SKIP_W-1:0] m;
    m = run - SKIP_W'(1);
    return fdsle_pkg::SKIP_CODE | {1'b0, 7'(m)};
  endfunction

  assign drain = (pend_count != '0) && (!out_valid || !out_stall);
  assign take  = q_valid && ((pend_count == '0) || (pend_count == CNT_W'(1) && drain));
  assign q_pop = take;

  always_comb begin
    logic [SKIP_W-1:0] sr;
    logic              la;
    logic [LIT_W-1:0]  lc;
    logic [OFS_W-1:0]  cs;
    logic [WPOS_W-1:0] wp;
    logic              hv;
    logic [7:0]        hb;
    logic [CNT_W-1:0]  n;
    sr = skip_run;
    la = literal_active;
    lc = literal_count;
    cs = count_slot;
    wp = write_position;
    hv = held_valid;
    hb = held_byte;
    n  = '0;
    for (int i = 0; i < NRES; i++) begin
      res[i] = '0;
    end

    if (!la) begin
      if (q_data.changed) begin
        if (sr != '0) begin
          res[n[IDX_W-1:0]] = body_word(skip_byte(sr), wp);
          n  = n + 1'b1;
          wp = wp + 1'b1;
          sr = '0;
        end
        // open literal, reserve the count slot
        cs = wp[OFS_W-1:0];
        wp = wp + 1'b1;
        la = 1'b1;
        lc = '0;
        hv = 1'b0;
        res[n[IDX_W-1:0]] = body_word(q_data.pixel_byte, wp);
        n  = n + 1'b1;
        wp = wp + 1'b1;
        lc = lc + 1'b1;
        if (lc >= LIT_W'(fdsle_pkg::MAX_LITERAL)) begin
          res[n[IDX_W-1:0]] = body_word(8'(lc), {1'b0, cs});
          n  = n + 1'b1;
          la = 1'b0;
          lc = '0;
          hv = 1'b0;
        end
      end else if (sr >= SKIP_W'(fdsle_pkg::MAX_SKIP)) begin
        res[n[IDX_W-1:0]] = body_word(skip_byte(SKIP_W'(fdsle_pkg::MAX_SKIP)), wp);
        n  = n + 1'b1;
        wp = wp + 1'b1;
        sr = SKIP_W'(1);
      end else begin
        sr = sr + 1'b1;
      end
    end else if (!q_data.changed) begin
      if (hv) begin
        res[n[IDX_W-1:0]] = body_word(8'(lc), {1'b0, cs});
        n  = n + 1'b1;
        la = 1'b0;
        lc = '0;
        hv = 1'b0;
        sr = SKIP_W'(2);
      end else if ({1'b0, lc} + 1'b1 >= (LIT_W + 1)'(fdsle_pkg::MAX_LITERAL)) begin
        res[n[IDX_W-1:0]] = body_word(8'(lc), {1'b0, cs});
        n  = n + 1'b1;
        la = 1'b0;
        lc = '0;
        hv = 1'b0;
        sr = SKIP_W'(1);
      end else begin
        hv = 1'b1;
        hb = q_data.pixel_byte;
      end
    end else begin
      if (hv) begin
        hv = 1'b0;
        res[n[IDX_W-1:0]] = body_word(hb, wp);
        n  = n + 1'b1;
        wp = wp + 1'b1;
        lc = lc + 1'b1;
        if (lc >= LIT_W'(fdsle_pkg::MAX_LITERAL)) begin
          res[n[IDX_W-1:0]] = body_word(8'(lc), {1'b0, cs});
          n  = n + 1'b1;
          la = 1'b0;
          lc = '0;
        end
      end
      if (!la) begin
        cs = wp[OFS_W-1:0];
        wp = wp + 1'b1;
        la = 1'b1;
        lc = '0;
        hv = 1'b0;
      end
      res[n[IDX_W-1:0]] = body_word(q_data.pixel_byte, wp);
      n  = n + 1'b1;
      wp = wp + 1'b1;
      lc = lc + 1'b1;
      if (lc >= LIT_W'(fdsle_pkg::MAX_LITERAL)) begin
        res[n[IDX_W-1:0]] = body_word(8'(lc), {1'b0, cs});
        n  = n + 1'b1;
        la = 1'b0;
        lc = '0;
        hv = 1'b0;
      end
    end

    if (q_data.last) begin
      if (la) begin
        res[n[IDX_W-1:0]] = body_word(8'(lc), {1'b0, cs});
        n  = n + 1'b1;
      end
      // trailing skip is dropped
      res[n[IDX_W-1:0]].out_byte    = '0;
      res[n[IDX_W-1:0]].out_offset  = '0;
      res[n[IDX_W-1:0]].out_trailer = 1'b1;
      res[n[IDX_W-1:0]].key_used    = q_data.key;
      res[n[IDX_W-1:0]].body_length = wp;
      n  = n + 1'b1;
      sr = '0;
      la = 1'b0;
      lc = '0;
      cs = '0;
      wp = '0;
      hv = 1'b0;
    end

    skip_run_next       = sr;
    literal_active_next = la;
    literal_count_next  = lc;
    count_slot_next     = cs;
    write_position_next = wp;
    held_valid_next     = hv;
    held_byte_next      = hb;
    res_count           = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_run       <= '0;
      literal_active <= 1'b0;
      literal_count  <= '0;
      count_slot     <= '0;
      write_position <= '0;
      held_valid     <= 1'b0;
      pend_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        skip_run       <= skip_run_next;
        literal_active <= literal_active_next;
        literal_count  <= literal_count_next;
        count_slot     <= count_slot_next;
        write_position <= write_position_next;
        held_valid     <= held_valid_next;
        pend_count     <= res_count;
      end else if (drain) begin
        pend_count <= pend_count - 1'b1;
      end
      if (!out_valid || !out_stall) begin
        out_valid <= pend_count != '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_byte <= held_byte_next;
      for (int i = 0; i < NRES; i++) begin
        pend[i] <= res[i];
      end
    end else if (drain) begin
      for (int i = 0; i < NRES - 1; i++) begin
        pend[i] <= pend[i + 1];
      end
    end
    if (!out_valid || !out_stall) begin
      out_data <= pend[0];
    end
  end

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend_count <= CNT_W'(NRES))
    else $error("result buffer holds more than its depth");

  a_trailer_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_trailer |-> out_data.out_byte == '0 && out_data.out_offset == '0)
    else $error("trailer word carries a body byte or offset");

  a_take_empty: assert property (@(posedge clk) disable iff (rst)
    take && res_count == '0 |=> pend_count == '0)
    else $error("result buffer not empty after a word with no results");
`endif

endmodule
`default_nettype wire

FILE: hdl/frame_delta_skip_literal_encoder.sv
// top level of the frame delta encoder with skip and literal codes
//
//   channel | direction | handshake                 | word
//   in      | input     | in_valid / in_stall       | fdsle_pkg::in_t
//   out     | output    | out_valid / out_stall     | fdsle_pkg::out_t
//   cfg     | input     | cfg_we                    | frame_length, 14 bits
//
// one byte a cycle enters while in_stall is low; results leave at one a cycle while out_stall is low,
// so a byte that yields k results (k is 0 to 4) holds the back end until its last result is drained
// input to first result passes memory read, queue, result buffer and output register
// the previous frame sits in a single read-before-write port memory, one access per byte
// rst is synchronous; the stored frame has no reset and is written before it is read
// out_stall holds the output register; the back end and then the queue fill before in_stall rises
`default_nettype none
module frame_delta_skip_literal_encoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire fdsle_pkg::in_t                in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output fdsle_pkg::out_t                    out_data,
  input  wire logic                          cfg_we,
  input  wire logic [fdsle_pkg::FLEN_W-1:0]  cfg_data
);

  fdsle_pkg::link_t front_link;
  fdsle_pkg::cls_t  front_word;
  fdsle_pkg::cls_t  back_word;
  logic             q_ready;
  logic             q_valid;
  logic             q_pop;

  fdsle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .q_link_out (front_link),
    .q_ready    (q_ready),
    .q_data     (front_word)
  );

  fdsle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_link  (front_link),
    .push_data  (front_word),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (back_word)
  );

  fdsle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (back_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// self-checking testbench for the frame delta skip/literal encoder
`default_nettype none
module testbench;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  localparam int MAX_FRAME_BYTES = fdsle_pkg::MAX_FRAME_BYTES;
  localparam int MAX_LITERAL     = fdsle_pkg::MAX_LITERAL;
  localparam int MAX_SKIP        = fdsle_pkg::MAX_SKIP;
  localparam int FLEN_W          = fdsle_pkg::FLEN_W;
  localparam int WPOS_W          = fdsle_pkg::WPOS_W;
  localparam int OFS_W           = fdsle_pkg::OFS_W;
  localparam logic [FLEN_W-1:0] FRAME_LENGTH_RESET = fdsle_pkg::FRAME_LENGTH_RESET;
  localparam logic [7:0]        SKIP_CODE          = fdsle_pkg::SKIP_CODE;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  fdsle_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fdsle_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [FLEN_W-1:0] cfg_data = '0;

  // encoder state as the block should hold it
  logic [7:0] prev_frame [MAX_FRAME_BYTES];
  logic [FLEN_W-1:0] frame_len = FRAME_LENGTH_RESET;
  int byte_pos = 0;
  int skip_run = 0;
  int lit_count = 0;
  bit lit_open = 1'b0;
  bit held_valid = 1'b0;
  logic [7:0] held_byte = '0;
  bit key_pending = 1'b1;
  bit key_in_frame = 1'b0;
  logic [WPOS_W-1:0] count_slot = '0;
  logic [WPOS_W-1:0] body_pos = '0;

  fdsle_pkg::out_t expected_codes [$];
  fdsle_pkg::in_t byte_queue [$];

  // stimulus side view of the stored frame, so that unwritten bytes are never compared
  logic [7:0] plan_prev [MAX_FRAME_BYTES];
  int plan_pos = 0;
  int plan_len = FRAME_LENGTH_RESET;
  int plan_extent = 0;
  bit plan_key = 1'b0;
  bit plan_key_bit = 1'b0;
  bit plan_key_pending = 1'b1;

  int sender_idle = 0;
  int stall_pct = 0;
  bit hold_phase = 1'b0;
  int hold_count = 0;
  logic in_fire = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;

  frame_delta_skip_literal_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void push_code(logic [7:0] code, logic [WPOS_W-1:0] ofs, logic trailer,
                                    logic key, logic [WPOS_W-1:0] blen);
    fdsle_pkg::out_t w;
    w.out_byte = code;
    w.out_offset = ofs[OFS_W-1:0];
    w.out_trailer = trailer;
    w.key_used = key;
    w.body_length = blen;
    expected_codes.push_back(w);
  endfunction

  function automatic void emit_skip(int n);
    push_code(SKIP_CODE | 8'(n - 1), body_pos, 1'b0, 1'b0, '0);
    body_pos = body_pos + 1'b1;
  endfunction

  function automatic void close_literal();
    push_code({1'b0, 7'(lit_count)}, count_slot, 1'b0, 1'b0, '0);
    lit_open = 1'b0;
    lit_count = 0;
    held_valid = 1'b0;
  endfunction

  function automatic void open_literal();
    count_slot = body_pos;
    body_pos = body_pos + 1'b1;
    lit_open = 1'b1;
    lit_count = 0;
    held_valid = 1'b0;
  endfunction

  function automatic void append_literal(logic [7:0] b);
    push_code(b, body_pos, 1'b0, 1'b0, '0);
    body_pos = body_pos + 1'b1;
    lit_count++;
    if (lit_count >= MAX_LITERAL) close_literal();
  endfunction

  function automatic void encode_byte(fdsle_pkg::in_t w);
    int lim;
    int p;
    logic [7:0] ref_byte;
    bit changed;
    bit last;
    lim = frame_len;
    if (lim == 0) lim = 1;
    if (lim > MAX_FRAME_BYTES) lim = MAX_FRAME_BYTES;
    p = byte_pos;
    if (p >= MAX_FRAME_BYTES) p = MAX_FRAME_BYTES - 1;
    last = w.frame_end || (p + 1 >= lim);
    if (p == 0) begin
      key_in_frame = key_pending || w.key_frame;
      key_pending = 1'b0;
    end
    ref_byte = key_in_frame ? 8'h00 : prev_frame[p];
    prev_frame[p] = w.pixel_byte;
    changed = (w.pixel_byte != ref_byte);
    if (!lit_open) begin
      if (changed) begin
        if (skip_run > 0) begin
          emit_skip(skip_run);
          skip_run = 0;
        end
        open_literal();
        append_literal(w.pixel_byte);
      end else if (skip_run >= MAX_SKIP) begin
        emit_skip(MAX_SKIP);
        skip_run = 1;
      end else begin
        skip_run++;
      end
    end else if (!changed) begin
      if (held_valid) begin
        close_literal();
        skip_run = 2;
      end else if (lit_count + 1 >= MAX_LITERAL) begin
        close_literal();
        skip_run = 1;
      end else begin
        held_valid = 1'b1;
        held_byte = w.pixel_byte;
      end
    end else begin
      if (held_valid) begin
        held_valid = 1'b0;
        append_literal(held_byte);
      end
      if (!lit_open) open_literal();
      append_literal(w.pixel_byte);
    end
    if (last) begin
      if (lit_open) close_literal();
      push_code(8'h00, '0, 1'b1, key_in_frame, body_pos);
      byte_pos = 0;
      skip_run = 0;
      lit_open = 1'b0;
      lit_count = 0;
      count_slot = '0;
      body_pos = '0;
      held_valid = 1'b0;
    end else begin
      byte_pos = p + 1;
    end
  endfunction

  function automatic void flag_error(string what, fdsle_pkg::out_t want, fdsle_pkg::out_t got);
    errors++;
    if (errors <= 10)
      $display("%s: want byte %0d ofs %0d trailer %0b key %0b len %0d", what, want.out_byte,
               want.out_offset, want.out_trailer, want.key_used, want.body_length,
               "; got byte %0d ofs %0d trailer %0b key %0b len %0d", got.out_byte,
               got.out_offset, got.out_trailer, got.key_used, got.body_length);
  endfunction

  // driver: word taken at the rising edge, next one offered at the falling edge
  always @(posedge clk) in_fire <= !rst && in_valid && !in_stall;

  always @(negedge clk) begin
    if (in_fire) encode_byte(in_data);
    if (!in_valid || in_fire) begin
      if (!rst && byte_queue.size() != 0 && $urandom_range(99) >= sender_idle) begin
        in_data <= byte_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_phase && hold_count < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count++;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    fdsle_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_codes.size() == 0) begin
        want = 'x;
        flag_error("unexpected word", want, out_data);
      end else begin
        want = expected_codes.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.out_offset !== want.out_offset ||
            out_data.out_trailer !== want.out_trailer || out_data.key_used !== want.key_used ||
            out_data.body_length !== want.body_length)
          flag_error("mismatch", want, out_data);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] plan_ref();
    return plan_key ? 8'h00 : plan_prev[plan_pos];
  endfunction

  task automatic begin_frame(int n, bit want_key);
    plan_key_bit = want_key;
    if (!plan_key_pending && n > plan_extent) plan_key_bit = 1'b1;
    plan_key = plan_key_pending || plan_key_bit;
    plan_key_pending = 1'b0;
  endtask

  task automatic put_byte(logic [7:0] b, bit close);
    fdsle_pkg::in_t w;
    bit natural;
    natural = (plan_pos + 1 >= plan_len);
    w.pixel_byte = b;
    w.key_frame = (plan_pos == 0) ? plan_key_bit : 1'($urandom_range(1));
    if (!close) w.frame_end = 1'b0;
    else if (natural) w.frame_end = ($urandom_range(2) == 0);
    else w.frame_end = 1'b1;
    byte_queue.push_back(w);
    plan_prev[plan_pos] = b;
    if (plan_pos + 1 > plan_extent) plan_extent = plan_pos + 1;
    if (close || natural) plan_pos = 0;
    else plan_pos++;
  endtask

  task automatic fill_frame(int n);
    int run_left;
    int r;
    bit run_same;
    run_left = 0;
    run_same = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        run_same = 1'($urandom_range(1));
        r = $urandom_range(15);
        if (r < 10) begin
          run_left = $urandom_range(1, 3);
        end else if (r < 14) begin
          run_left = $urandom_range(4, 12);
        end else begin
          case ($urandom_range(3))
            0: run_left = MAX_LITERAL - 1;
            1: run_left = MAX_LITERAL;
            2: run_left = MAX_SKIP;
            default: run_left = $urandom_range(MAX_SKIP + 1, 300);
          endcase
        end
      end
      put_byte(run_same ? plan_ref() : plan_ref() ^ 8'($urandom_range(1, 255)), i == n - 1);
      run_left--;
    end
  endtask

  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_valid || expected_codes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(logic [FLEN_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    frame_len = v;
    key_pending = 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    plan_len = (v == 0) ? 1 : ((v > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : v);
    plan_key_pending = 1'b1;
  endtask

  task automatic run_phase(int idle, int stall, logic [FLEN_W-1:0] len, int target, bit hold);
    int queued;
    int n;
    int cap;
    write_length(len);
    sender_idle = idle;
    stall_pct = stall;
    hold_phase = hold;
    queued = 0;
    while (queued < target) begin
      cap = (plan_len < 24) ? plan_len : 24;
      n = $urandom_range(1, cap);
      begin_frame(n, $urandom_range(3) == 0);
      fill_frame(n);
      queued += n;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // held byte inside a literal, two unchanged closing it, trailing skip dropped
    begin_frame(8, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hA5, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h5A, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b1);
    // delta against the previous frame, held byte at frame end
    begin_frame(6, 1'b0);
    put_byte(plan_ref(), 1'b0);
    put_byte(plan_ref(), 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(plan_ref(), 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(plan_ref(), 1'b1);
    // frame ended by its length
    write_length(14'd3);
    begin_frame(3, 1'b0);
    put_byte(8'h80, 1'b0);
    put_byte(plan_ref(), 1'b0);
    put_byte(8'h7F, 1'b1);
    // zero length counts as one byte
    write_length(14'd0);
    begin_frame(1, 1'b1);
    put_byte(plan_ref(), 1'b1);
    begin_frame(1, 1'b0);
    put_byte(8'h01, 1'b1);
    // length above the store size
    write_length(14'h3FFF);
    begin_frame(4, 1'b0);
    put_byte(8'hC3, 1'b0);
    put_byte(plan_ref(), 1'b0);
    put_byte(plan_ref(), 1'b0);
    put_byte(8'h3C, 1'b1);
    // length shortened mid-frame, next byte ends it
    begin_frame(4, 1'b0);
    put_byte(8'h11, 1'b0);
    put_byte(plan_ref(), 1'b0);
    put_byte(8'h22, 1'b0);
    write_length(14'd2);
    put_byte(8'h33, 1'b1);

    run_phase(0, 0, 14'($urandom_range(1, 400)), 16, 1'b1);
    run_phase(87, 0, 14'(MAX_FRAME_BYTES), 16, 1'b0);
    run_phase(0, 87, 14'($urandom_range(1, 400)), 16, 1'b0);
    run_phase(14, 14, 14'd1, 16, 1'b0);

    wait_idle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
